### hw/rtl/light_sensor_tracker_stepper_defines.svh
// ----------------------------------------------------------------------------
// Light sensor tracker stepper: assertion macros
// Shared macros for the concurrent checks on the stepper ports.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_TRACKER_STEPPER_DEFINES_SVH
`define LIGHT_SENSOR_TRACKER_STEPPER_DEFINES_SVH

// Check a property on every clock edge outside of reset
`define LST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define LST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/lst_pkg.sv
// ----------------------------------------------------------------------------
// Light sensor tracker stepper package
// Word types, angle limits and the step and dead band helpers.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int FIELD_W = 12;
    localparam int ANGLE_W = 8;
    // Signed room for a difference of two 12-bit samples and a negated band
    localparam int DIFF_W  = 14;

    localparam logic [ANGLE_W-1:0] PAN_MIN    = 8'd0;
    localparam logic [ANGLE_W-1:0] PAN_MAX    = 8'd180;
    localparam logic [ANGLE_W-1:0] TILT_MIN   = 8'd20;
    localparam logic [ANGLE_W-1:0] TILT_MAX   = 8'd160;
    localparam logic [ANGLE_W-1:0] TILT_FLIP  = 8'd90;
    localparam logic [ANGLE_W-1:0] HOME_ANGLE = 8'd90;

    typedef logic [1:0] t_dir;
    localparam t_dir DIR_HOLD = 2'd0;
    localparam t_dir DIR_UP   = 2'd1;
    localparam t_dir DIR_DOWN = 2'd2;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [ANGLE_W-1:0]       t_angle;

    typedef struct packed {
        logic [FIELD_W-1:0] dual_top_left;
        logic [FIELD_W-1:0] dual_top_right;
        logic [FIELD_W-1:0] dual_bottom_left;
        logic [FIELD_W-1:0] dual_bottom_right;
        logic [FIELD_W-1:0] single_left;
        logic [FIELD_W-1:0] single_right;
        logic [FIELD_W-1:0] single_top;
        logic [FIELD_W-1:0] single_bottom;
    } t_in_word;

    typedef struct packed {
        t_angle dual_pan_angle;
        t_angle dual_tilt_angle;
        t_angle single_pan_angle;
        t_angle single_tilt_angle;
    } t_out_word;

    // Up if either difference clears the band, else down if either falls below -band
    function automatic t_dir judge2(t_diff d1, t_diff d2, logic [FIELD_W-1:0] band);
        t_diff pos;
        t_diff neg;
        t_dir  r;
        pos = t_diff'({2'b00, band});
        neg = -pos;
        priority if (d1 > pos || d2 > pos) begin
            r = DIR_UP;
        end else if (d1 < neg || d2 < neg) begin
            r = DIR_DOWN;
        end else begin
            r = DIR_HOLD;
        end
        return r;
    endfunction

    // Reverse a step direction
    function automatic t_dir flip(t_dir d);
        t_dir r;
        unique case (d)
            DIR_UP:   r = DIR_DOWN;
            DIR_DOWN: r = DIR_UP;
            default:  r = DIR_HOLD;
        endcase
        return r;
    endfunction

    // Step one degree and clamp to the limits
    function automatic t_angle step_sat(t_angle a, t_dir d, t_angle lo, t_angle hi);
        t_angle r;
        unique case (d)
            DIR_UP:   r = (a >= hi) ? hi : a + 8'd1;
            DIR_DOWN: r = (a <= lo) ? lo : a - 8'd1;
            default:  r = a;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/lst_in_if.sv
// ----------------------------------------------------------------------------
// Light sensor tracker stepper: sample channel
// Valid/ready channel that carries one word of eight sensor samples.
// ----------------------------------------------------------------------------
interface lst_in_if;
    import lst_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/lst_out_if.sv
// ----------------------------------------------------------------------------
// Light sensor tracker stepper: angle channel
// Valid/ready channel that carries one word of four servo angles.
// ----------------------------------------------------------------------------
interface lst_out_if;
    import lst_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/light_sensor_tracker_stepper.sv
// ----------------------------------------------------------------------------
// Light sensor tracker stepper
// Dead band step control of the pan and tilt servos of two sun trackers.
// ----------------------------------------------------------------------------
// Each sample word moves every servo angle by at most one degree toward the
// brighter side, and the word out is the four angles after that step. The block
// takes one word per clock while the output is not stalled. An accepted word
// goes first into the input register, then through the compare-and-step logic
// into the angle registers, which are the output register. Back pressure on the
// output holds the angles; one more word may wait in the input register.
module light_sensor_tracker_stepper #(
    parameter int SENSOR_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lst_pkg::FIELD_W-1:0] i_cfg_wr_data,
    lst_in_if.sink                      i_in,
    lst_out_if.source                   o_out
);
    import lst_pkg::*;

    // Sample bits that reach the compare; the fields carry no more than FIELD_W
    localparam int SMP_W = (SENSOR_BITS < FIELD_W) ? SENSOR_BITS : FIELD_W;

    logic [FIELD_W-1:0] r_band;
    logic               r_in_vld;
    t_in_word           r_in;
    logic               r_out_vld;
    t_angle             r_dual_pan,   n_dual_pan;
    t_angle             r_dual_tilt,  n_dual_tilt;
    t_angle             r_single_pan, n_single_pan;
    t_angle             r_single_tilt, n_single_tilt;

    logic out_free;
    logic adv;

    t_diff d_tl_tr, d_bl_br, d_tr_br, d_tl_bl, d_sl_sr, d_st_sb;
    t_dir  j_dpan, j_dtilt, j_span, j_stilt, dir_dpan;

    // Handshake: the result slot frees when empty or taken
    assign out_free    = !r_out_vld || o_out.ready;
    assign adv         = r_in_vld && out_free;
    assign i_in.ready  = !r_in_vld || out_free;

    // Dead band register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= '0;
        end else if (i_cfg_wr_en) begin
            r_band <= i_cfg_wr_data;
        end
    end

    // Input register: load a new word when the slot empties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // Signed pair differences on the used sample bits
    assign d_tl_tr = t_diff'(r_in.dual_top_left[SMP_W-1:0])
                   - t_diff'(r_in.dual_top_right[SMP_W-1:0]);
    assign d_bl_br = t_diff'(r_in.dual_bottom_left[SMP_W-1:0])
                   - t_diff'(r_in.dual_bottom_right[SMP_W-1:0]);
    assign d_tr_br = t_diff'(r_in.dual_top_right[SMP_W-1:0])
                   - t_diff'(r_in.dual_bottom_right[SMP_W-1:0]);
    assign d_tl_bl = t_diff'(r_in.dual_top_left[SMP_W-1:0])
                   - t_diff'(r_in.dual_bottom_left[SMP_W-1:0]);
    assign d_sl_sr = t_diff'(r_in.single_left[SMP_W-1:0])
                   - t_diff'(r_in.single_right[SMP_W-1:0]);
    assign d_st_sb = t_diff'(r_in.single_top[SMP_W-1:0])
                   - t_diff'(r_in.single_bottom[SMP_W-1:0]);

    // Dead band decisions
    assign j_dpan  = judge2(d_tl_tr, d_bl_br, r_band);
    assign j_dtilt = judge2(d_tr_br, d_tl_bl, r_band);
    assign j_span  = judge2(d_sl_sr, d_sl_sr, r_band);
    assign j_stilt = judge2(d_st_sb, d_st_sb, r_band);

    // Reverse the two-axis pan while the old tilt is past the flip angle
    assign dir_dpan = (r_dual_tilt > TILT_FLIP) ? flip(j_dpan) : j_dpan;

    // Step and clamp each angle
    always_comb begin
        n_dual_pan    = step_sat(r_dual_pan, dir_dpan, PAN_MIN, PAN_MAX);
        n_dual_tilt   = step_sat(r_dual_tilt, flip(j_dtilt), TILT_MIN, TILT_MAX);
        n_single_pan  = step_sat(r_single_pan, flip(j_span), PAN_MIN, PAN_MAX);
        n_single_tilt = step_sat(r_single_tilt, j_stilt, TILT_MIN, TILT_MAX);
    end

    // Angle registers double as the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld     <= 1'b0;
            r_dual_pan    <= HOME_ANGLE;
            r_dual_tilt   <= HOME_ANGLE;
            r_single_pan  <= HOME_ANGLE;
            r_single_tilt <= HOME_ANGLE;
        end else begin
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (adv) begin
                r_dual_pan    <= n_dual_pan;
                r_dual_tilt   <= n_dual_tilt;
                r_single_pan  <= n_single_pan;
                r_single_tilt <= n_single_tilt;
            end
        end
    end

    // Drive the result word
    assign o_out.valid                  = r_out_vld;
    assign o_out.data.dual_pan_angle    = r_dual_pan;
    assign o_out.data.dual_tilt_angle   = r_dual_tilt;
    assign o_out.data.single_pan_angle  = r_single_pan;
    assign o_out.data.single_tilt_angle = r_single_tilt;

endmodule

### hw/rtl/lst_checker.sv
// ----------------------------------------------------------------------------
// Light sensor tracker stepper checker
// Port-level checks on the angle word, bound to the top level.
// ----------------------------------------------------------------------------
`include "light_sensor_tracker_stepper_defines.svh"

module lst_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input lst_pkg::t_out_word   i_out_data
);
    import lst_pkg::*;

    // Angles stay inside their travel
    `LST_ASSERT(a_range, i_out_valid |-> (i_out_data.dual_pan_angle <= PAN_MAX && i_out_data.single_pan_angle <= PAN_MAX && i_out_data.dual_tilt_angle >= TILT_MIN && i_out_data.dual_tilt_angle <= TILT_MAX && i_out_data.single_tilt_angle >= TILT_MIN && i_out_data.single_tilt_angle <= TILT_MAX), "angle out of range")

    // The dual pan and single tilt angles move at most one degree per cycle
    `LST_ASSERT(a_step_pan, ##1 (i_out_data.dual_pan_angle == $past(i_out_data.dual_pan_angle) || i_out_data.dual_pan_angle == $past(i_out_data.dual_pan_angle) + 8'd1 || i_out_data.dual_pan_angle == $past(i_out_data.dual_pan_angle) - 8'd1), "dual pan jumped")

    `LST_ASSERT(a_step_tilt, ##1 (i_out_data.single_tilt_angle == $past(i_out_data.single_tilt_angle) || i_out_data.single_tilt_angle == $past(i_out_data.single_tilt_angle) + 8'd1 || i_out_data.single_tilt_angle == $past(i_out_data.single_tilt_angle) - 8'd1), "single tilt jumped")

    // A stalled word holds
    `LST_ASSERT(a_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "stalled word changed")

    // Reset empties the output and homes the angles; the dual pair is checked
    `LST_ASSERT_ALWAYS(a_reset, !i_rst_n |=> (!i_out_valid && i_out_data.dual_pan_angle == HOME_ANGLE && i_out_data.dual_tilt_angle == HOME_ANGLE), "reset state wrong")

endmodule

bind light_sensor_tracker_stepper lst_checker u_lst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
